[design/maze_flood_fill_router_macros.svh]
// assertion macros for the maze flood fill router
`ifndef MAZE_FLOOD_FILL_ROUTER_MACROS_SVH
`define MAZE_FLOOD_FILL_ROUTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition holds at every clock edge out of reset
`define MFFR_ASSERT_HOLDS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("maze router check failed");

// antecedent implies consequent in the same cycle
`define MFFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("maze router check failed");

`else

`define MFFR_ASSERT_HOLDS(lbl, clk, rst_n, cond)
`define MFFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`endif

`endif

[design/mffr_pkg.sv]
// types and constants shared by the maze flood fill router
package mffr_pkg;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic [1:0] heading;
    logic [7:0] relative_walls;
    logic       goal_flag;
    logic [7:0] raw_entry;
  } in_item_t;

  typedef struct packed {
    logic [7:0] distance;
    logic       reachable;
    logic       move_found;
    logic [1:0] next_move;
  } out_item_t;

  // commands
  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_GOAL   = 2'd1;
  localparam logic [1:0] CMD_ROUTE  = 2'd2;
  localparam logic [1:0] CMD_RAW    = 2'd3;

  // configuration register indexes
  localparam logic CFG_START_X = 1'b0;
  localparam logic CFG_START_Y = 1'b1;

  // absolute directions
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  // mirrored wall masks
  localparam logic [7:0] MASK_N2     = 8'h88;
  localparam logic [7:0] MASK_E2     = 8'h44;
  localparam logic [7:0] MASK_S2     = 8'h22;
  localparam logic [7:0] MASK_W2     = 8'h11;
  localparam logic [7:0] START_FORCE = 8'h77;
  localparam logic [3:0] START_NIB   = 4'h7;

  // relative move tried at each priority slot: straight, right, left, back
  localparam logic [1:0] MOVE_ORDER [4] = '{2'd0, 2'd1, 2'd3, 2'd2};

endpackage

[design/mffr_ram.sv]
// generic simple dual port ram with registered read
module mffr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/maze_flood_fill_router.sv]
// maze flood fill router: wall map, goal flags, breadth-first flood and route
//
// Input beats (in_valid/in_stall, in_data) carry one command each; every command
// gives exactly one result beat (out_valid/out_stall, out_data). Commands:
// record sensed walls, set or clear a goal flag, flood and route, write a raw
// wall entry. The start cell is set over the cfg_we/cfg_index/cfg_wdata port.
// The block works on one command at a time; in_stall is high while busy.
// Each map memory has a single read port, so a command runs as a series of
// states: a goal or raw write passes a write state; record walls writes the
// cell, then reads and rewrites each neighbor or start cell touched; flood and
// route sweeps the distance map, expands each cell taken off the flood queue
// and then searches for a move. A record or route on a cell outside the grid
// goes straight to its result. Results sit in an output register, so the next
// command is taken while a result waits; a stalled result holds and the block
// pauses only when a second result is ready. After reset a clearing pass over
// all GRID_SIZE*GRID_SIZE cells zeroes the wall and goal maps with in_stall
// high; config writes go through.
`include "maze_flood_fill_router_macros.svh"

module maze_flood_fill_router #(
  parameter int GRID_SIZE = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mffr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mffr_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [3:0]          cfg_wdata
);

  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int CW    = $clog2(GRID_SIZE);
  localparam int IW    = $clog2(CELLS);
  localparam int DW    = IW + 1;
  localparam int TW    = IW + 1;
  localparam int QW    = 2 * CW;

  localparam logic [CW-1:0] LAST     = CW'(GRID_SIZE - 1);
  localparam logic [DW-1:0] D_UNKNOWN = {DW{1'b1}};

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_WR        = 4'd2;
  localparam logic [3:0] S_REC_WR    = 4'd3;
  localparam logic [3:0] S_REC_RD    = 4'd4;
  localparam logic [3:0] S_REC_MOD   = 4'd5;
  localparam logic [3:0] S_SWEEP     = 4'd6;
  localparam logic [3:0] S_SWEEP_END = 4'd7;
  localparam logic [3:0] S_POP       = 4'd8;
  localparam logic [3:0] S_CUR       = 4'd9;
  localparam logic [3:0] S_EXP0      = 4'd10;
  localparam logic [3:0] S_EXP       = 4'd11;
  localparam logic [3:0] S_RES0      = 4'd12;
  localparam logic [3:0] S_RES1      = 4'd13;
  localparam logic [3:0] S_RES2      = 4'd14;
  localparam logic [3:0] S_DONE      = 4'd15;

  // record walls sub steps
  localparam logic [2:0] OP_N     = 3'd1;
  localparam logic [2:0] OP_E     = 3'd2;
  localparam logic [2:0] OP_S     = 3'd3;
  localparam logic [2:0] OP_W     = 3'd4;
  localparam logic [2:0] OP_START = 3'd5;
  localparam logic [2:0] OP_EAST  = 3'd6;

  function automatic logic [IW-1:0] cell_idx(logic [CW-1:0] x, logic [CW-1:0] y);
    cell_idx = IW'(y) * IW'(GRID_SIZE) + IW'(x);
  endfunction

  function automatic logic [CW-1:0] step_x(logic [CW-1:0] x, logic [1:0] a);
    case (a)
      mffr_pkg::DIR_E: step_x = x + CW'(1);
      mffr_pkg::DIR_W: step_x = x - CW'(1);
      default:         step_x = x;
    endcase
  endfunction

  function automatic logic [CW-1:0] step_y(logic [CW-1:0] y, logic [1:0] a);
    case (a)
      mffr_pkg::DIR_N: step_y = y + CW'(1);
      mffr_pkg::DIR_S: step_y = y - CW'(1);
      default:         step_y = y;
    endcase
  endfunction

  // open side that stays inside the grid
  function automatic logic nb_ok(logic [CW-1:0] x, logic [CW-1:0] y, logic [3:0] w,
                                 logic [1:0] a);
    case (a)
      mffr_pkg::DIR_N: nb_ok = !w[3] && (y != LAST);
      mffr_pkg::DIR_E: nb_ok = !w[2] && (x != LAST);
      mffr_pkg::DIR_S: nb_ok = !w[1] && (y != '0);
      default:         nb_ok = !w[0] && (x != '0);
    endcase
  endfunction

  // control registers
  logic [3:0]    state_r, state_nxt;
  logic [IW-1:0] lin_r, lin_nxt;
  logic [TW-1:0] head_r, head_nxt;
  logic [TW-1:0] tail_r, tail_nxt;
  logic          hit_r, hit_nxt;
  logic          sw_pend_r, sw_pend_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [1:0]    dir_r, dir_nxt;
  logic          nbv_r, nbv_nxt;
  logic [3:0]    start_x_r, start_x_nxt;
  logic [3:0]    start_y_r, start_y_nxt;

  // payload registers
  mffr_pkg::in_item_t  item_r, item_nxt;
  logic                inside_r, inside_nxt;
  logic [CW-1:0]       sx_r, sx_nxt, sy_r, sy_nxt;
  logic [CW-1:0]       sw_x_r, sw_y_r;
  logic [IW-1:0]       sw_lin_r;
  logic [CW-1:0]       cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [DW-1:0]       step_r, step_nxt;
  logic [3:0]          walls_r, walls_nxt;
  logic [DW-1:0]       cur_d_r, cur_d_nxt;
  logic [IW-1:0]       nb_addr_r, nb_addr_nxt;
  logic [CW-1:0]       nb_x_r, nb_x_nxt, nb_y_r, nb_y_nxt;
  mffr_pkg::out_item_t res_r, res_nxt;
  mffr_pkg::out_item_t out_data_r, out_data_nxt;

  // memory ports
  logic          w_we, g_we, d_we, q_we;
  logic [IW-1:0] w_waddr, w_raddr, g_waddr, d_waddr, d_raddr;
  logic [7:0]    w_wdata, wall_rd;
  logic          g_wdata, goal_rd;
  logic [DW-1:0] d_wdata, dist_rd;
  logic [QW-1:0] q_wdata, q_rd;

  logic [CW-1:0] tx, ty;
  logic [IW-1:0] tgt_idx;
  logic          start_in, start_east, start_match;
  logic [IW-1:0] s_idx;
  logic [3:0]    wn;
  logic [7:0]    w8;
  logic          rec_ok, rec_set;
  logic [IW-1:0] rec_addr;
  logic [7:0]    rec_bits;
  logic          iss_first, iss_res, iss_ok;
  logic [1:0]    iss_k, iss_a;
  logic [CW-1:0] iss_x, iss_y, iss_nx, iss_ny;
  logic [3:0]    iss_w;
  logic [IW-1:0] iss_idx;
  logic          sw_goal;

  mffr_ram #(.WIDTH(8), .DEPTH(CELLS)) u_wall_ram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(wall_rd)
  );

  mffr_ram #(.WIDTH(1), .DEPTH(CELLS)) u_goal_ram (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(lin_r), .rdata(goal_rd)
  );

  mffr_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_dist_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(dist_rd)
  );

  mffr_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(tail_r[IW-1:0]), .wdata(q_wdata),
    .raddr(head_r[IW-1:0]), .rdata(q_rd)
  );

  assign tx          = CW'(item_r.cell_x);
  assign ty          = CW'(item_r.cell_y);
  assign tgt_idx     = cell_idx(tx, ty);
  assign start_in    = (int'(start_x_r) < GRID_SIZE) && (int'(start_y_r) < GRID_SIZE);
  assign start_east  = (int'(start_x_r) + 1) < GRID_SIZE;
  assign start_match = (item_r.cell_x == start_x_r) && (item_r.cell_y == start_y_r);
  assign s_idx       = cell_idx(CW'(start_x_r), CW'(start_y_r));

  // sensed walls rotated to absolute, start cell closed on three sides
  always_comb begin
    wn = 4'(item_r.relative_walls >> item_r.heading);
    if (start_match) begin
      wn = wn | mffr_pkg::START_NIB;
    end
    w8 = {wn, wn};
  end

  always_comb begin
    rec_ok   = 1'b0;
    rec_set  = 1'b1;
    rec_addr = s_idx;
    rec_bits = mffr_pkg::START_FORCE;
    case (op_r)
      OP_N: begin
        rec_ok   = ty != LAST;
        rec_addr = cell_idx(tx, ty + CW'(1));
        rec_set  = w8[7];
        rec_bits = mffr_pkg::MASK_S2;
      end
      OP_E: begin
        rec_ok   = tx != LAST;
        rec_addr = cell_idx(tx + CW'(1), ty);
        rec_set  = w8[6];
        rec_bits = mffr_pkg::MASK_W2;
      end
      OP_S: begin
        rec_ok   = ty != '0;
        rec_addr = cell_idx(tx, ty - CW'(1));
        rec_set  = w8[5];
        rec_bits = mffr_pkg::MASK_N2;
      end
      OP_W: begin
        rec_ok   = tx != '0;
        rec_addr = cell_idx(tx - CW'(1), ty);
        rec_set  = w8[4];
        rec_bits = mffr_pkg::MASK_E2;
      end
      OP_START: begin
        rec_ok = start_in;
      end
      OP_EAST: begin
        rec_ok   = start_in && start_east;
        rec_addr = s_idx + IW'(1);
        rec_bits = mffr_pkg::MASK_W2;
      end
      default: begin
        rec_ok = 1'b0;
      end
    endcase
  end

  // neighbor read issue, shared by flood expansion and move search
  always_comb begin
    iss_first = (state_r == S_EXP0) || (state_r == S_RES1);
    iss_res   = (state_r == S_RES1) || (state_r == S_RES2);
    iss_k     = iss_first ? 2'd0 : dir_r + 2'd1;
    iss_a     = iss_res ? item_r.heading + mffr_pkg::MOVE_ORDER[iss_k] : iss_k;
    iss_x     = iss_res ? tx : cur_x_r;
    iss_y     = iss_res ? ty : cur_y_r;
    iss_w     = iss_first ? wall_rd[3:0] : walls_r;
    iss_nx    = step_x(iss_x, iss_a);
    iss_ny    = step_y(iss_y, iss_a);
    iss_ok    = nb_ok(iss_x, iss_y, iss_w, iss_a);
    iss_idx   = cell_idx(iss_nx, iss_ny);
  end

  assign sw_goal = goal_rd && (sw_lin_r != '0);

  always_comb begin
    state_nxt     = state_r;
    lin_nxt       = lin_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    hit_nxt       = hit_r;
    sw_pend_nxt   = (state_r == S_SWEEP);
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    dir_nxt       = dir_r;
    nbv_nxt       = nbv_r;
    start_x_nxt   = start_x_r;
    start_y_nxt   = start_y_r;
    item_nxt      = item_r;
    inside_nxt    = inside_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    step_nxt      = step_r;
    walls_nxt     = walls_r;
    cur_d_nxt     = cur_d_r;
    nb_addr_nxt   = nb_addr_r;
    nb_x_nxt      = nb_x_r;
    nb_y_nxt      = nb_y_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;

    w_we    = 1'b0;
    w_waddr = tgt_idx;
    w_wdata = item_r.raw_entry;
    w_raddr = tgt_idx;
    g_we    = 1'b0;
    g_waddr = tgt_idx;
    g_wdata = item_r.goal_flag;
    d_we    = 1'b0;
    d_waddr = nb_addr_r;
    d_wdata = step_r + DW'(1);
    d_raddr = tgt_idx;
    q_we    = 1'b0;
    q_wdata = {nb_y_r, nb_x_r};

    if (cfg_we) begin
      if (cfg_index == mffr_pkg::CFG_START_X) begin
        start_x_nxt = cfg_wdata;
      end else begin
        start_y_nxt = cfg_wdata;
      end
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // second half of the distance sweep: goal flag read last cycle
    if (sw_pend_r) begin
      d_we    = 1'b1;
      d_waddr = sw_lin_r;
      d_wdata = sw_goal ? '0 : D_UNKNOWN;
      if (sw_goal) begin
        q_we     = 1'b1;
        q_wdata  = {sw_y_r, sw_x_r};
        tail_nxt = tail_r + TW'(1);
        if (sw_lin_r == tgt_idx) begin
          hit_nxt = 1'b1;
        end
      end
    end

    unique case (state_r)
      S_CLEAR: begin
        w_we    = 1'b1;
        w_waddr = lin_r;
        w_wdata = '0;
        g_we    = 1'b1;
        g_waddr = lin_r;
        g_wdata = 1'b0;
        lin_nxt = lin_r + IW'(1);
        if (lin_r == IW'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          item_nxt   = in_data;
          inside_nxt = (int'(in_data.cell_x) < GRID_SIZE) &&
                       (int'(in_data.cell_y) < GRID_SIZE);
          res_nxt    = '0;
          case (in_data.command)
            mffr_pkg::CMD_RECORD: begin
              state_nxt = inside_nxt ? S_REC_WR : S_DONE;
            end
            mffr_pkg::CMD_ROUTE: begin
              if (inside_nxt) begin
                head_nxt  = '0;
                tail_nxt  = '0;
                hit_nxt   = 1'b0;
                lin_nxt   = '0;
                sx_nxt    = '0;
                sy_nxt    = '0;
                state_nxt = S_SWEEP;
              end else begin
                res_nxt.distance = 8'hFF;
                state_nxt        = S_DONE;
              end
            end
            default: begin
              state_nxt = S_WR;
            end
          endcase
        end
      end

      S_WR: begin
        if (inside_r) begin
          if (item_r.command == mffr_pkg::CMD_RAW) begin
            w_we = 1'b1;
          end else if (!(item_r.cell_x == 4'd0 && item_r.cell_y == 4'd0)) begin
            g_we = 1'b1;
          end
        end
        state_nxt = S_DONE;
      end

      S_REC_WR: begin
        w_we      = 1'b1;
        w_wdata   = w8;
        op_nxt    = OP_N;
        state_nxt = S_REC_RD;
      end

      S_REC_RD: begin
        w_raddr = rec_addr;
        if (rec_ok) begin
          state_nxt = S_REC_MOD;
        end else if (op_r == OP_EAST) begin
          state_nxt = S_DONE;
        end else begin
          op_nxt = op_r + 3'd1;
        end
      end

      S_REC_MOD: begin
        w_we    = 1'b1;
        w_waddr = rec_addr;
        w_wdata = rec_set ? (wall_rd | rec_bits) : (wall_rd & ~rec_bits);
        if (op_r == OP_EAST) begin
          state_nxt = S_DONE;
        end else begin
          op_nxt    = op_r + 3'd1;
          state_nxt = S_REC_RD;
        end
      end

      S_SWEEP: begin
        lin_nxt = lin_r + IW'(1);
        if (sx_r == LAST) begin
          sx_nxt = '0;
          sy_nxt = sy_r + CW'(1);
        end else begin
          sx_nxt = sx_r + CW'(1);
        end
        if (lin_r == IW'(CELLS - 1)) begin
          state_nxt = S_SWEEP_END;
        end
      end

      S_SWEEP_END: begin
        state_nxt = S_POP;
      end

      S_POP: begin
        if (hit_r || head_r == tail_r) begin
          state_nxt = S_RES0;
        end else begin
          head_nxt  = head_r + TW'(1);
          state_nxt = S_CUR;
        end
      end

      S_CUR: begin
        cur_x_nxt = q_rd[CW-1:0];
        cur_y_nxt = q_rd[QW-1:CW];
        d_raddr   = cell_idx(q_rd[CW-1:0], q_rd[QW-1:CW]);
        w_raddr   = d_raddr;
        state_nxt = S_EXP0;
      end

      S_EXP0: begin
        step_nxt    = dist_rd;
        walls_nxt   = wall_rd[3:0];
        d_raddr     = iss_idx;
        nbv_nxt     = iss_ok;
        nb_addr_nxt = iss_idx;
        nb_x_nxt    = iss_nx;
        nb_y_nxt    = iss_ny;
        dir_nxt     = iss_k;
        state_nxt   = S_EXP;
      end

      S_EXP: begin
        // claim the neighbor read last cycle if nobody reached it yet
        if (nbv_r && dist_rd == D_UNKNOWN) begin
          d_we     = 1'b1;
          q_we     = 1'b1;
          tail_nxt = tail_r + TW'(1);
          if (nb_addr_r == tgt_idx) begin
            hit_nxt = 1'b1;
          end
        end
        if (dir_r == mffr_pkg::DIR_W) begin
          state_nxt = S_POP;
        end else begin
          d_raddr     = iss_idx;
          nbv_nxt     = iss_ok;
          nb_addr_nxt = iss_idx;
          nb_x_nxt    = iss_nx;
          nb_y_nxt    = iss_ny;
          dir_nxt     = iss_k;
        end
      end

      S_RES0: begin
        state_nxt = S_RES1;
      end

      S_RES1: begin
        cur_d_nxt = dist_rd;
        walls_nxt = wall_rd[3:0];
        if (dist_rd == D_UNKNOWN) begin
          res_nxt.distance  = 8'hFF;
          res_nxt.reachable = 1'b0;
        end else begin
          res_nxt.distance  = (int'(dist_rd) > 255) ? 8'hFF : 8'(dist_rd);
          res_nxt.reachable = 1'b1;
        end
        d_raddr     = iss_idx;
        nbv_nxt     = iss_ok;
        nb_addr_nxt = iss_idx;
        dir_nxt     = iss_k;
        state_nxt   = S_RES2;
      end

      S_RES2: begin
        if (nbv_r && (dist_rd < cur_d_r) && !res_r.move_found) begin
          res_nxt.move_found = 1'b1;
          res_nxt.next_move  = mffr_pkg::MOVE_ORDER[dir_r];
        end
        if (dir_r == 2'd3) begin
          state_nxt = S_DONE;
        end else begin
          d_raddr     = iss_idx;
          nbv_nxt     = iss_ok;
          nb_addr_nxt = iss_idx;
          dir_nxt     = iss_k;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      lin_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      hit_r       <= 1'b0;
      sw_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      op_r        <= OP_N;
      dir_r       <= '0;
      nbv_r       <= 1'b0;
      start_x_r   <= '0;
      start_y_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      lin_r       <= lin_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      hit_r       <= hit_nxt;
      sw_pend_r   <= sw_pend_nxt;
      out_valid_r <= out_valid_nxt;
      op_r        <= op_nxt;
      dir_r       <= dir_nxt;
      nbv_r       <= nbv_nxt;
      start_x_r   <= start_x_nxt;
      start_y_r   <= start_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    inside_r   <= inside_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    sw_x_r     <= sx_r;
    sw_y_r     <= sy_r;
    sw_lin_r   <= lin_r;
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    step_r     <= step_nxt;
    walls_r    <= walls_nxt;
    cur_d_r    <= cur_d_nxt;
    nb_addr_r  <= nb_addr_nxt;
    nb_x_r     <= nb_x_nxt;
    nb_y_r     <= nb_y_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MFFR_ASSERT_HOLDS(a_queue_order, clk, rst_n, head_r <= tail_r)
  `MFFR_ASSERT_HOLDS(a_queue_bound, clk, rst_n, tail_r <= TW'(CELLS))
  `MFFR_ASSERT_IMP(a_result_from_done, clk, rst_n, out_valid_r && !$past(out_valid_r), $past(state_r) == S_DONE)

endmodule
